// ===== src/ftrr_pkg.sv =====
package ftrr_pkg;

   localparam logic [1:0] MODE_GAME   = 2'd0;
   localparam logic [1:0] MODE_RENDER = 2'd1;
   localparam logic [1:0] MODE_SNAP   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SNAP
   } state_type;

   typedef struct packed {
      logic [63:0] frame_number;
      logic [31:0] wall_time;
      logic [31:0] sim_step_time;
      logic [31:0] pacer_wait_time;
      logic [31:0] inflight_wait_time;
      logic [31:0] game_work_time;
      logic [31:0] render_exec_time;
      logic [31:0] present_wait_time;
      logic        render_done;
   } record_type;

   localparam int REC_W = $bits(record_type);

endpackage

// ===== src/ftrr_ram.sv =====
module ftrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/frame_timing_ring_recorder_unit.sv =====
// Game frame (mode 0): written in the accepting cycle, busy stays low.
// Render completion (mode 1): busy; up to min(count, LOOKBACK) probes, one probe per
//   cycle through the single read port of the record memory; early exit on a match.
// Snapshot (mode 2): N records, read in ST_SNAP with rsp_valid registered, one per cycle.
// Results cannot be stalled. Synchronous active-high reset clears the record count
//   and control state; record memory contents are left as they are.
module frame_timing_ring_recorder_unit
   import ftrr_pkg::*;
#(
   parameter int CAPACITY = 64,
   parameter int LOOKBACK = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_frame_number,
   input  logic [31:0] req_wall_time,
   input  logic [31:0] req_sim_step_time,
   input  logic [31:0] req_pacer_wait_time,
   input  logic [31:0] req_inflight_wait_time,
   input  logic [31:0] req_game_work_time,
   input  logic [31:0] req_render_exec_time,
   input  logic [31:0] req_present_wait_time,
   input  logic [6:0]  req_requested_count,
   output logic        rsp_valid,
   output logic [63:0] rsp_out_frame_number,
   output logic [31:0] rsp_out_wall_time,
   output logic [31:0] rsp_out_sim_step_time,
   output logic [31:0] rsp_out_pacer_wait_time,
   output logic [31:0] rsp_out_inflight_wait_time,
   output logic [31:0] rsp_out_game_work_time,
   output logic [31:0] rsp_out_render_exec_time,
   output logic [31:0] rsp_out_present_wait_time,
   output logic        rsp_out_render_done,
   output logic        rsp_out_last,
   output logic [63:0] rsp_out_total_recorded
);

   localparam int PTR_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int LOOK_W = $clog2(LOOKBACK + 1);

   state_type        state_ff, state_in;
   logic [63:0]      count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] probe_addr_ff, probe_addr_in;
   logic [LOOK_W-1:0] issue_ff, issue_in;
   logic [LOOK_W-1:0] look_ff, look_in;
   logic [63:0]      key_ff, key_in;
   logic [31:0]      render_ff, render_in;
   logic [31:0]      present_ff, present_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [PTR_W-1:0] cmp_addr_ff, cmp_addr_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [PTR_W-1:0] snap_addr_ff, snap_addr_in;
   logic [63:0]      total_ff, total_in;
   logic             rv_ff, rv_in;
   logic             last_ff, last_in;

   logic             accept;
   logic             match;
   logic [CNT_W-1:0] avail;
   logic [CNT_W-1:0] want;
   logic [LOOK_W-1:0] look_start;
   logic [SUM_W-1:0] snap_start_sum;

   logic             ram_we;
   logic [PTR_W-1:0] ram_waddr;
   record_type       ram_wdata;
   logic             ram_re;
   logic [PTR_W-1:0] ram_raddr;
   record_type       ram_rdata;

   ftrr_ram #(
      .WIDTH(REC_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign match  = cmp_valid_ff && (ram_rdata.frame_number == key_ff);

   assign avail = (count_ff < 64'(CAPACITY)) ? count_ff[CNT_W-1:0] : CNT_W'(CAPACITY);
   assign want  = (req_requested_count < 7'(avail)) ? req_requested_count[CNT_W-1:0] : avail;
   assign look_start = (count_ff < 64'(LOOKBACK)) ? count_ff[LOOK_W-1:0] : LOOK_W'(LOOKBACK);
   assign snap_start_sum = SUM_W'(wr_ptr_ff)
                         + ((SUM_W'(wr_ptr_ff) >= SUM_W'(want)) ? '0 : SUM_W'(CAPACITY))
                         - SUM_W'(want);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_RENDER) begin
               state_in = ST_SEARCH;
            end else if (accept && req_mode == MODE_SNAP && want != '0) begin
               state_in = ST_SNAP;
            end
         end
         ST_SEARCH: begin
            if (match || issue_ff == look_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_SNAP: begin
            if (left_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      wr_ptr_in     = wr_ptr_ff;
      probe_addr_in = probe_addr_ff;
      issue_in      = issue_ff;
      look_in       = look_ff;
      key_in        = key_ff;
      render_in     = render_ff;
      present_in    = present_ff;
      cmp_valid_in  = 1'b0;
      cmp_addr_in   = cmp_addr_ff;
      left_in       = left_ff;
      snap_addr_in  = snap_addr_ff;
      total_in      = total_ff;
      rv_in         = 1'b0;
      last_in       = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = wr_ptr_ff;
      ram_wdata     = ram_rdata;
      ram_re        = 1'b0;
      ram_raddr     = probe_addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_GAME) begin
               ram_we                       = 1'b1;
               ram_wdata.frame_number       = req_frame_number;
               ram_wdata.wall_time          = req_wall_time;
               ram_wdata.sim_step_time      = req_sim_step_time;
               ram_wdata.pacer_wait_time    = req_pacer_wait_time;
               ram_wdata.inflight_wait_time = req_inflight_wait_time;
               ram_wdata.game_work_time     = req_game_work_time;
               ram_wdata.render_exec_time   = '0;
               ram_wdata.present_wait_time  = '0;
               ram_wdata.render_done        = 1'b0;
               count_in  = count_ff + 64'd1;
               wr_ptr_in = (wr_ptr_ff == PTR_W'(CAPACITY - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
            end else if (accept && req_mode == MODE_RENDER) begin
               key_in        = req_frame_number;
               render_in     = req_render_exec_time;
               present_in    = req_present_wait_time;
               look_in       = look_start;
               issue_in      = '0;
               probe_addr_in = (wr_ptr_ff == '0) ? PTR_W'(CAPACITY - 1)
                                                 : wr_ptr_ff - PTR_W'(1);
            end else if (accept && req_mode == MODE_SNAP) begin
               left_in      = want;
               snap_addr_in = snap_start_sum[PTR_W-1:0];
               total_in     = count_ff;
            end
         end
         ST_SEARCH: begin
            if (issue_ff != look_ff) begin
               ram_re        = 1'b1;
               ram_raddr     = probe_addr_ff;
               issue_in      = issue_ff + LOOK_W'(1);
               probe_addr_in = (probe_addr_ff == '0) ? PTR_W'(CAPACITY - 1)
                                                     : probe_addr_ff - PTR_W'(1);
               cmp_valid_in  = 1'b1;
               cmp_addr_in   = probe_addr_ff;
            end
            if (match) begin
               ram_we                      = 1'b1;
               ram_waddr                   = cmp_addr_ff;
               ram_wdata.render_exec_time  = render_ff;
               ram_wdata.present_wait_time = present_ff;
               ram_wdata.render_done       = 1'b1;
            end
         end
         ST_SNAP: begin
            ram_re       = 1'b1;
            ram_raddr    = snap_addr_ff;
            left_in      = left_ff - CNT_W'(1);
            snap_addr_in = (snap_addr_ff == PTR_W'(CAPACITY - 1)) ? '0
                                                                   : snap_addr_ff + PTR_W'(1);
            rv_in        = 1'b1;
            last_in      = (left_ff == CNT_W'(1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wr_ptr_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         rv_ff        <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wr_ptr_ff    <= wr_ptr_in;
         cmp_valid_ff <= cmp_valid_in;
         rv_ff        <= rv_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_addr_ff <= probe_addr_in;
      issue_ff      <= issue_in;
      look_ff       <= look_in;
      key_ff        <= key_in;
      render_ff     <= render_in;
      present_ff    <= present_in;
      cmp_addr_ff   <= cmp_addr_in;
      left_ff       <= left_in;
      snap_addr_ff  <= snap_addr_in;
      total_ff      <= total_in;
   end

   assign rsp_valid                  = rv_ff;
   assign rsp_out_last               = last_ff;
   assign rsp_out_total_recorded     = total_ff;
   assign rsp_out_frame_number       = ram_rdata.frame_number;
   assign rsp_out_wall_time          = ram_rdata.wall_time;
   assign rsp_out_sim_step_time      = ram_rdata.sim_step_time;
   assign rsp_out_pacer_wait_time    = ram_rdata.pacer_wait_time;
   assign rsp_out_inflight_wait_time = ram_rdata.inflight_wait_time;
   assign rsp_out_game_work_time     = ram_rdata.game_work_time;
   assign rsp_out_render_exec_time   = ram_rdata.render_exec_time;
   assign rsp_out_present_wait_time  = ram_rdata.present_wait_time;
   assign rsp_out_render_done        = ram_rdata.render_done;

endmodule

// ===== src/ftrr_checker.sv =====
module ftrr_checker
   import ftrr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_out_last,
   input logic [63:0] rsp_out_total_recorded
);

   // a non-snapshot transfer never produces a result
   a_no_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode != MODE_SNAP) |=> !rsp_valid)
      else $error("result after a non-snapshot request");

   a_stream_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_last) |=> rsp_valid)
      else $error("gap inside a snapshot stream");

   a_stream_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_last) |=> !rsp_valid)
      else $error("result after the last record");

   a_total_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_last) |=> $stable(rsp_out_total_recorded))
      else $error("total count changed inside a snapshot");

   a_busy_mid_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_last) |-> busy)
      else $error("idle while a snapshot is still streaming");

endmodule

bind frame_timing_ring_recorder_unit ftrr_checker u_ftrr_checker (.*);
